// ----- rtl/trf_pkg.sv -----
// Shared types, codes and widths of the threshold ring FIFO.
package trf_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int DATA_W     = 32;
   localparam int MODE_W     = 2;
   localparam int OFFS_W     = 4;
   localparam int STAT_W     = 3;
   localparam int OCC_W      = 5;
   localparam int MIN_FILL_W = 5;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 5;
   localparam int REQ_DATA_W = 40;  // push_data + peek_offset, padded to bytes
   localparam int RSP_DATA_W = 40;  // read_data + occupancy, padded to bytes

   // operation codes
   localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PEEK  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FLUSH = 2'd3;

   // result status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
   localparam logic [STAT_W-1:0] STAT_LOW_FILL = 3'd2;
   localparam logic [STAT_W-1:0] STAT_DISABLED = 3'd3;
   localparam logic [STAT_W-1:0] STAT_BAD_OFFS = 3'd4;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_FILL    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_PUSH_ENABLE = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_POP_ENABLE  = 2'd2;

   // per-cell control
   typedef struct packed {
      logic load;   // capture the pushed handle
      logic shift;  // take the neighbor's entry (toward the head)
   } cell_ctrl_type;

endpackage

// ----- rtl/trf_cell.sv -----
// One storage cell of the FIFO chain; entries move toward the head on a shift.
module trf_cell
   import trf_pkg::*;
(
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [DATA_W-1:0] push_data,
   input  logic [DATA_W-1:0] next_data,
   output logic [DATA_W-1:0] data
);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.shift) begin
         data_in = next_data;
      end else if (ctrl.load) begin
         data_in = push_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

// ----- rtl/threshold_ring_fifo.sv -----
// Top level of the threshold FIFO: control, config registers and the cell chain.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------------
//  req_    | in  | req_tvalid/req_tready | tuser: mode; tdata: push_data, peek_offset
//  rsp_    | out | rsp_tvalid/rsp_tready | tuser: status; tdata: read_data, occupancy
//  csr_    | in  | csr_we                | csr_addr register index, csr_wdata value
//
// Push, pop and peek: one beat per clock when rsp_ is not stalled.
// Flush of a non-empty FIFO sends one beat out per cycle while rsp_ is not stalled, as the
//   cell chain shifts its head out; req_tready stays low until the last beat is loaded.
// One output register separates the sides: a new beat is taken while the previous
//   result waits, as long as rsp_tready frees the register in the same cycle.
// Reset (synchronous, active high) empties the FIFO and sets min_fill 0, both enables 1.
module threshold_ring_fifo
   import trf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   // request stream
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [31:0] push_data, [35:32] peek_offset
   input  logic [MODE_W-1:0]     req_tuser,   // [1:0] mode
   // response stream
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [31:0] read_data, [36:32] occupancy
   output logic [STAT_W-1:0]     rsp_tuser,   // [2:0] status
   output logic                  rsp_tlast,
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int THR_W  = (CNT_W > MIN_FILL_W) ? CNT_W : MIN_FILL_W;
   localparam int OFC_W  = (CNT_W > OFFS_W) ? CNT_W : OFFS_W;
   // peek_offset reaches only the first 16 cells
   localparam int PEEK_N = (DEPTH < (1 << OFFS_W)) ? DEPTH : (1 << OFFS_W);

   // config registers
   logic [MIN_FILL_W-1:0] min_fill_ff, min_fill_in;
   logic                  push_en_ff, push_en_in;
   logic                  pop_en_ff, pop_en_in;

   // occupancy and flush sequencing
   logic [CNT_W-1:0] count_ff, count_in;
   logic             flush_ff, flush_in;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_stat_ff, rsp_stat_in;
   logic [DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [OCC_W-1:0]  rsp_occ_ff, rsp_occ_in;
   logic              rsp_last_ff, rsp_last_in;

   // cell chain
   logic [DATA_W-1:0] cell_q [DEPTH];
   logic [DATA_W-1:0] cell_next [DEPTH];
   cell_ctrl_type     cell_ctrl [DEPTH];

   // request fields
   logic [MODE_W-1:0] mode;
   logic [DATA_W-1:0] push_data;
   logic [OFFS_W-1:0] peek_offset;

   logic              out_free;
   logic              accept;
   logic              push_ok;
   logic              shift_all;
   logic              emit;
   logic [DATA_W-1:0] peek_data;

   assign mode        = req_tuser;
   assign push_data   = req_tdata[DATA_W-1:0];
   assign peek_offset = req_tdata[DATA_W+OFFS_W-1:DATA_W];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !flush_ff && out_free;
   assign accept     = req_tvalid && req_tready;

   // peek mux over the reachable cells
   always_comb begin
      peek_data = '0;
      for (int i = 0; i < PEEK_N; i++) begin
         if (peek_offset == OFFS_W'(i)) begin
            peek_data = cell_q[i];
         end
      end
   end

   // config writes
   always_comb begin
      min_fill_in = min_fill_ff;
      push_en_in  = push_en_ff;
      pop_en_in   = pop_en_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_MIN_FILL:    min_fill_in = csr_wdata[MIN_FILL_W-1:0];
            CSR_PUSH_ENABLE: push_en_in  = csr_wdata[0];
            CSR_POP_ENABLE:  pop_en_in   = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // operation decode
   always_comb begin
      count_in    = count_ff;
      flush_in    = flush_ff;
      push_ok     = 1'b0;
      shift_all   = 1'b0;
      emit        = 1'b0;
      rsp_stat_in = STAT_OK;
      rsp_data_in = '0;
      rsp_occ_in  = OCC_W'(count_ff);
      rsp_last_in = 1'b1;

      if (flush_ff) begin
         // drain one entry per free output slot
         if (out_free) begin
            emit        = 1'b1;
            shift_all   = 1'b1;
            rsp_data_in = cell_q[0];
            rsp_occ_in  = '0;
            rsp_last_in = (count_ff == CNT_W'(1));
            count_in    = count_ff - CNT_W'(1);
            flush_in    = (count_ff != CNT_W'(1));
         end
      end else if (accept) begin
         unique case (mode)
            MODE_PUSH: begin
               emit = 1'b1;
               if (!push_en_ff) begin
                  rsp_stat_in = STAT_DISABLED;
               end else if (count_ff == CNT_W'(DEPTH)) begin
                  rsp_stat_in = STAT_FULL;
               end else begin
                  push_ok    = 1'b1;
                  count_in   = count_ff + CNT_W'(1);
                  rsp_occ_in = OCC_W'(count_in);
               end
            end
            MODE_POP: begin
               emit = 1'b1;
               if (!pop_en_ff) begin
                  rsp_stat_in = STAT_DISABLED;
               end else if (THR_W'(count_ff) <= THR_W'(min_fill_ff)) begin
                  rsp_stat_in = STAT_LOW_FILL;
               end else begin
                  shift_all   = 1'b1;
                  rsp_data_in = cell_q[0];
                  count_in    = count_ff - CNT_W'(1);
                  rsp_occ_in  = OCC_W'(count_in);
               end
            end
            MODE_PEEK: begin
               emit = 1'b1;
               if (!pop_en_ff) begin
                  rsp_stat_in = STAT_DISABLED;
               end else if (OFC_W'(peek_offset) >= OFC_W'(count_ff)) begin
                  rsp_stat_in = STAT_BAD_OFFS;
               end else begin
                  rsp_data_in = peek_data;
               end
            end
            MODE_FLUSH: begin
               // empty FIFO answers at once; otherwise the drain starts next cycle
               if (count_ff == '0) begin
                  emit = 1'b1;
               end else begin
                  flush_in = 1'b1;
               end
            end
            default: ;
         endcase
      end

      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   // cell chain: cell 0 is the head, push lands at cell count_ff
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == DEPTH - 1) begin : g_tail
         assign cell_next[g] = '0;
      end else begin : g_mid
         assign cell_next[g] = cell_q[g+1];
      end
      assign cell_ctrl[g].load  = push_ok && (count_ff == CNT_W'(g));
      assign cell_ctrl[g].shift = shift_all;

      trf_cell u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl[g]),
         .push_data (push_data),
         .next_data (cell_next[g]),
         .data      (cell_q[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_fill_ff  <= '0;
         push_en_ff   <= 1'b1;
         pop_en_ff    <= 1'b1;
         count_ff     <= '0;
         flush_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_fill_ff  <= min_fill_in;
         push_en_ff   <= push_en_in;
         pop_en_ff    <= pop_en_in;
         count_ff     <= count_in;
         flush_ff     <= flush_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload of the output register, loaded only with a new beat
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_stat_ff <= rsp_stat_in;
         rsp_data_ff <= rsp_data_in;
         rsp_occ_ff  <= rsp_occ_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - DATA_W - OCC_W){1'b0}}, rsp_occ_ff, rsp_data_ff};

`ifndef SYNTHESIS
   // occupancy never passes the chain length
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("occupancy beyond depth");

   // a drain only runs with entries left
   a_flush_nonempty: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> (count_ff != '0))
      else $error("flush running on empty chain");

   // no request is taken while draining
   a_flush_blocks: assert property (@(posedge clock) disable iff (reset)
      flush_ff |-> !req_tready)
      else $error("request accepted during flush");

   // the final drain beat leaves the FIFO empty and idle
   a_flush_ends: assert property (@(posedge clock) disable iff (reset)
      (flush_ff && out_free && count_ff == CNT_W'(1)) |=> (!flush_ff && count_ff == '0))
      else $error("flush did not end cleanly");

   // a successful push grows occupancy by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      push_ok |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("push did not advance occupancy");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking bench for the threshold ring FIFO: directed table, then random phases.
module tb_top;
   import trf_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FIFO_DEPTH  = DEPTH_DEFAULT;
   // Quiet-cycle limit. The longest legal quiet stretch is the receiver hold-off,
   // so this is several times that.
   localparam int QUIET_LIMIT = 1000;

   // One response beat, field by field.
   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [DATA_W-1:0] read_data;
      logic [OCC_W-1:0]  occupancy;
      logic              last;
   } fifo_result_type;

   // A directed row is either a request beat or a register write.
   typedef enum logic {ROW_OP, ROW_REG} row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      logic [1:0]        code;    // mode for ROW_OP, register index for ROW_REG
      logic [DATA_W-1:0] value;   // push_data, or the register value
      logic [OFFS_W-1:0] offs;
      logic              typed;   // expectation written into the row
      fifo_result_type   exp;
   } stim_row_type;

   // Random phase: idle rates, register setting and op mix.
   typedef struct {
      int                    send_pct;
      int                    recv_pct;
      logic [MIN_FILL_W-1:0] min_fill;
      logic                  push_en;
      logic                  pop_en;
      int                    items;
      logic                  fill_bias;
      int                    hold;
   } phase_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [31:0] push_data, [35:32] peek_offset
   logic [MODE_W-1:0]     req_tuser;   // [1:0] mode
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [31:0] read_data, [36:32] occupancy
   logic [STAT_W-1:0]     rsp_tuser;   // [2:0] status
   logic                  rsp_tlast;
   logic                  csr_we;
   logic [CSR_ADDR_W-1:0] csr_addr;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // Shadow copy of the FIFO: 5-bit read and write counters wrap modulo 2*DEPTH.
   logic [DATA_W-1:0]     shadow_slots [FIFO_DEPTH];
   logic [OCC_W-1:0]      shadow_wr       = '0;
   logic [OCC_W-1:0]      shadow_rd       = '0;
   logic [MIN_FILL_W-1:0] shadow_min_fill = '0;
   logic                  shadow_push_en  = 1'b1;
   logic                  shadow_pop_en   = 1'b1;

   fifo_result_type step_results[$];     // beats caused by the request being predicted
   fifo_result_type pending_results[$];  // beats still owed by the block, oldest first

   int send_idle_pct    = 0;
   int rsp_stall_pct    = 0;
   int rsp_hold_request = 0;
   int hold_left        = 0;
   int quiet_cycles     = 0;
   int error_count      = 0;
   int req_beats        = 0;
   int rsp_beats        = 0;
   int reg_writes       = 0;
   int status_seen [8]  = '{default: 0};

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   threshold_ring_fifo uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   function automatic fifo_result_type fifo_result(input logic [STAT_W-1:0] status,
                                                   input logic [DATA_W-1:0] rdata,
                                                   input logic [OCC_W-1:0]  occ,
                                                   input logic              last);
      fifo_result_type r;
      r.status    = status;
      r.read_data = rdata;
      r.occupancy = occ;
      r.last      = last;
      return r;
   endfunction

   // Works out the beats one request causes and advances the shadow FIFO.
   function automatic void predict_fifo_results(input logic [1:0]        mode,
                                                input logic [DATA_W-1:0] data,
                                                input logic [OFFS_W-1:0] offs);
      logic [OCC_W-1:0] lvl;
      logic [OCC_W-1:0] idx;
      lvl = shadow_wr - shadow_rd;
      step_results.delete();
      case (mode)
         MODE_PUSH: begin
            // disable wins over full
            if (!shadow_push_en) begin
               step_results.push_back(fifo_result(STAT_DISABLED, '0, lvl, 1'b1));
            end else if (lvl >= FIFO_DEPTH) begin
               step_results.push_back(fifo_result(STAT_FULL, '0, lvl, 1'b1));
            end else begin
               shadow_slots[shadow_wr[3:0]] = data;
               shadow_wr = shadow_wr + 1'b1;
               step_results.push_back(fifo_result(STAT_OK, '0, lvl + 1'b1, 1'b1));
            end
         end
         MODE_POP: begin
            if (!shadow_pop_en) begin
               step_results.push_back(fifo_result(STAT_DISABLED, '0, lvl, 1'b1));
            end else if (lvl <= shadow_min_fill) begin
               step_results.push_back(fifo_result(STAT_LOW_FILL, '0, lvl, 1'b1));
            end else begin
               step_results.push_back(fifo_result(STAT_OK, shadow_slots[shadow_rd[3:0]],
                                                  lvl - 1'b1, 1'b1));
               shadow_rd = shadow_rd + 1'b1;
            end
         end
         MODE_PEEK: begin
            // threshold does not apply to peek
            idx = shadow_rd + {1'b0, offs};
            if (!shadow_pop_en) begin
               step_results.push_back(fifo_result(STAT_DISABLED, '0, lvl, 1'b1));
            end else if ({1'b0, offs} >= lvl) begin
               step_results.push_back(fifo_result(STAT_BAD_OFFS, '0, lvl, 1'b1));
            end else begin
               step_results.push_back(fifo_result(STAT_OK, shadow_slots[idx[3:0]], lvl, 1'b1));
            end
         end
         MODE_FLUSH: begin
            // ignores both enables; an empty flush still gives one closing beat
            if (lvl == 0) begin
               step_results.push_back(fifo_result(STAT_OK, '0, '0, 1'b1));
            end
            for (int i = 0; i < lvl; i++) begin
               idx = shadow_rd + OCC_W'(i);
               step_results.push_back(fifo_result(STAT_OK, shadow_slots[idx[3:0]], '0,
                                                  (i == lvl - 1)));
            end
            shadow_wr = '0;
            shadow_rd = '0;
         end
      endcase
   endfunction

   function automatic stim_row_type op_row(input logic [1:0]        mode,
                                           input logic [DATA_W-1:0] data,
                                           input logic [OFFS_W-1:0] offs);
      stim_row_type r;
      r       = '0;
      r.kind  = ROW_OP;
      r.code  = mode;
      r.value = data;
      r.offs  = offs;
      return r;
   endfunction

   function automatic stim_row_type op_exp(input logic [1:0]        mode,
                                           input logic [DATA_W-1:0] data,
                                           input logic [OFFS_W-1:0] offs,
                                           input logic [STAT_W-1:0] status,
                                           input logic [DATA_W-1:0] rdata,
                                           input logic [OCC_W-1:0]  occ);
      stim_row_type r;
      r       = op_row(mode, data, offs);
      r.typed = 1'b1;
      r.exp   = fifo_result(status, rdata, occ, 1'b1);
      return r;
   endfunction

   function automatic stim_row_type reg_row(input logic [CSR_ADDR_W-1:0] addr,
                                            input logic [CSR_DATA_W-1:0] value);
      stim_row_type r;
      r       = '0;
      r.kind  = ROW_REG;
      r.code  = addr;
      r.value = DATA_W'(value);
      return r;
   endfunction

   // Offers one request beat (after random sender gaps), waits for the handshake
   // and books the beats it must cause. A typed row replaces the predicted beat.
   task automatic send_op(input logic [1:0]        mode,
                          input logic [DATA_W-1:0] data,
                          input logic [OFFS_W-1:0] offs,
                          input logic              typed,
                          input fifo_result_type   typed_exp);
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {{(REQ_DATA_W-OFFS_W-DATA_W){1'b0}}, offs, data};
      do @(posedge clock); while (!req_tready);
      req_beats++;
      predict_fifo_results(mode, data, offs);
      if (typed) begin
         pending_results.push_back(typed_exp);
      end else begin
         foreach (step_results[i]) pending_results.push_back(step_results[i]);
      end
   endtask

   // Stop offering, wait until every owed beat has come out, and then let the
   // cell chain go quiet before registers change.
   task automatic drain_responses();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      reg_writes++;
      case (addr)
         CSR_MIN_FILL:    shadow_min_fill = value;
         CSR_PUSH_ENABLE: shadow_push_en  = value[0];
         CSR_POP_ENABLE:  shadow_pop_en   = value[0];
         default: ;
      endcase
   endtask

   // Receiver: random stalls at the phase rate, plus a counted hold-off on request.
   initial begin : rsp_sink
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request != 0) begin
            hold_left        = rsp_hold_request;
            rsp_hold_request = 0;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Response checker: every beat against the oldest owed beat.
   always @(posedge clock) begin : rsp_check
      fifo_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         rsp_beats++;
         status_seen[rsp_tuser]++;
         if (pending_results.size() == 0) begin
            $error("response beat with nothing owed: status %0d read_data %h",
                   rsp_tuser, rsp_tdata[DATA_W-1:0]);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_tuser);
               error_count++;
            end
            if (rsp_tdata[DATA_W-1:0] !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data,
                      rsp_tdata[DATA_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[DATA_W +: OCC_W] !== want.occupancy) begin
               $error("occupancy: expected %0d, got %0d", want.occupancy,
                      rsp_tdata[DATA_W +: OCC_W]);
               error_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_tlast);
               error_count++;
            end
         end
      end
   end

   // Watchdog: too long without a beat on either side means the block hung.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("timeout: %0d cycles without a beat, %0d beats still owed",
                     QUIET_LIMIT, pending_results.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin : stimulus
      stim_row_type      directed[$];
      phase_type         phases[6];
      fifo_result_type   no_exp;
      logic [1:0]        mode;
      logic [DATA_W-1:0] data;
      logic [OFFS_W-1:0] offs;
      logic [OCC_W-1:0]  lvl;
      int unsigned       pick;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = MODE_PUSH;
      csr_we     = 1'b0;
      csr_addr   = CSR_MIN_FILL;
      csr_wdata  = '0;
      no_exp     = '0;

      // Directed rows. Expectations are typed where they are obvious; the rest
      // go through the predictor.
      directed = '{
         // empty FIFO straight out of reset
         op_exp(MODE_POP,   32'h0,        4'd0,  STAT_LOW_FILL, 32'h0,        5'd0),
         op_exp(MODE_PEEK,  32'h0,        4'd0,  STAT_BAD_OFFS, 32'h0,        5'd0),
         op_exp(MODE_FLUSH, 32'h0,        4'd0,  STAT_OK,       32'h0,        5'd0),
         op_exp(MODE_PEEK,  32'h0,        4'd15, STAT_BAD_OFFS, 32'h0,        5'd0),
         // data extremes, ignored fields set
         op_exp(MODE_PUSH,  32'hFFFF_FFFF, 4'd0,  STAT_OK,       32'h0,        5'd1),
         op_exp(MODE_PUSH,  32'h0,        4'd15, STAT_OK,       32'h0,        5'd2),
         op_exp(MODE_PEEK,  32'hFFFF_FFFF, 4'd1,  STAT_OK,       32'h0,        5'd2),
         op_exp(MODE_PEEK,  32'h0,        4'd2,  STAT_BAD_OFFS, 32'h0,        5'd2),
         op_exp(MODE_POP,   32'h0,        4'd0,  STAT_OK,       32'hFFFF_FFFF, 5'd1),
         // push disabled, flush of one entry
         reg_row(CSR_PUSH_ENABLE, 5'd0),
         op_exp(MODE_PUSH,  32'hA5A5_A5A5, 4'd0,  STAT_DISABLED, 32'h0,        5'd1),
         op_row(MODE_FLUSH, 32'h0,        4'd0),
         // pop and peek disabled; flush still works
         reg_row(CSR_PUSH_ENABLE, 5'd1),
         reg_row(CSR_POP_ENABLE,  5'd0),
         op_row(MODE_PUSH,  32'h1234_5678, 4'd0),
         op_exp(MODE_POP,   32'h0,        4'd0,  STAT_DISABLED, 32'h0,        5'd1),
         op_exp(MODE_PEEK,  32'h0,        4'd0,  STAT_DISABLED, 32'h0,        5'd1),
         op_row(MODE_FLUSH, 32'h0,        4'd0),
         // threshold at the FIFO depth: every pop refused, peek unaffected
         reg_row(CSR_POP_ENABLE,  5'd1),
         reg_row(CSR_MIN_FILL,    5'd16),
         op_row(MODE_PUSH,  32'h5A5A_5A5A, 4'd0),
         op_row(MODE_PUSH,  32'h8000_0001, 4'd0),
         op_row(MODE_PUSH,  32'h7FFF_FFFE, 4'd0),
         op_exp(MODE_POP,   32'h0,        4'd0,  STAT_LOW_FILL, 32'h0,        5'd3),
         op_row(MODE_PEEK,  32'h0,        4'd2),
         // pop exactly at the threshold boundary
         reg_row(CSR_MIN_FILL,    5'd2),
         op_row(MODE_POP,   32'h0,        4'd0),
         op_exp(MODE_POP,   32'h0,        4'd0,  STAT_LOW_FILL, 32'h0,        5'd2),
         reg_row(CSR_MIN_FILL,    5'd0),
         op_row(MODE_FLUSH, 32'h0,        4'd0)
      };

      // send%, recv%, min_fill, push_en, pop_en, items, fill bias, hold-off
      phases = '{
         '{ 0,  0, 5'd0,  1'b1, 1'b1, 40, 1'b0,  0},  // back to back
         '{55,  0, 5'd3,  1'b1, 1'b1, 40, 1'b0,  0},  // sender gaps
         '{ 0, 55, 5'd16, 1'b1, 1'b1, 40, 1'b1, 80},  // fills up behind a held receiver
         '{32, 32, 5'd15, 1'b1, 1'b1, 40, 1'b1,  0},  // both idle, near full
         '{32, 32, 5'd0,  1'b0, 1'b0, 15, 1'b0,  0},  // everything but flush disabled
         '{ 0,  0, 5'd1,  1'b1, 1'b1, 30, 1'b0,  0}   // back to back again
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_REG) begin
            drain_responses();
            write_reg(directed[i].code, directed[i].value[CSR_DATA_W-1:0]);
         end else begin
            send_op(directed[i].code, directed[i].value, directed[i].offs,
                    directed[i].typed, directed[i].exp);
         end
      end

      foreach (phases[p]) begin
         drain_responses();
         send_idle_pct = phases[p].send_pct;
         rsp_stall_pct = phases[p].recv_pct;
         write_reg(CSR_MIN_FILL,    phases[p].min_fill);
         write_reg(CSR_PUSH_ENABLE, CSR_DATA_W'(phases[p].push_en));
         write_reg(CSR_POP_ENABLE,  CSR_DATA_W'(phases[p].pop_en));
         // receiver goes quiet while the sender keeps pushing: output register
         // fills and req_tready must drop
         rsp_hold_request = phases[p].hold;
         for (int n = 0; n < phases[p].items; n++) begin
            // halfway through, the sender waits for every owed beat
            if (n == phases[p].items / 2) drain_responses();
            lvl  = shadow_wr - shadow_rd;
            pick = $urandom_range(99);
            case ($urandom_range(9))
               0:       data = '0;
               1:       data = '1;
               default: data = $urandom;
            endcase
            offs = OFFS_W'($urandom_range(15));
            if ($urandom_range(9) == 0) begin
               // noise: any mode, any fields
               mode = MODE_W'($urandom_range(3));
            end else begin
               if (phases[p].fill_bias) begin
                  mode = (pick < 75) ? MODE_PUSH : (pick < 85) ? MODE_POP :
                         (pick < 98) ? MODE_PEEK : MODE_FLUSH;
               end else begin
                  mode = (pick < 40) ? MODE_PUSH : (pick < 65) ? MODE_POP :
                         (pick < 92) ? MODE_PEEK : MODE_FLUSH;
               end
               // peeks mostly land inside the stored range
               if (mode == MODE_PEEK && lvl != 0 && $urandom_range(3) != 0) begin
                  offs = OFFS_W'($urandom_range(lvl - 1));
               end
            end
            send_op(mode, data, offs, 1'b0, no_exp);
         end
      end

      drain_responses();
      repeat (16) @(posedge clock);

      $display("Covered %0d request beats and %0d response beats over %0d register writes",
               req_beats, rsp_beats, reg_writes);
      $display("Statuses seen: ok %0d, full %0d, low fill %0d, disabled %0d, bad offset %0d",
               status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_LOW_FILL],
               status_seen[STAT_DISABLED], status_seen[STAT_BAD_OFFS]);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
